[src/waveform_tone_generator_unit_macros.svh]
// Assertion macros shared by the tone generator RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef WAVEFORM_TONE_GENERATOR_UNIT_MACROS_SVH
`define WAVEFORM_TONE_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define WTG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WTG_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/wtg_pkg.sv]
// Shared types, codes and the sine table builder for the tone generator.
// No dependencies.
package wtg_pkg;

	localparam int unsigned SINE_MAG_W = 15;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned STEP_W = 32;
	localparam int unsigned VOLUME_W = 16;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned LFSR_W = 16;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [SINE_MAG_W-1:0] FULL_SCALE = 15'h7FFF;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int unsigned SERIES_TERMS = 6;
	localparam int unsigned SeriesDiv [SERIES_TERMS] = '{6, 20, 42, 72, 110, 156};

	typedef enum logic [1:0] {
		WAVE_SINE,
		WAVE_SAW,
		WAVE_SQUARE,
		WAVE_NOISE
	} wave_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_WAVE,
		CFG_STEP,
		CFG_VOLUME,
		CFG_STEREO
	} cfg_reg_t;

	typedef struct packed {
		logic                  is_sine;
		logic                  neg;
		logic [SINE_MAG_W-1:0] mag;
	} wave_beat_t;

	// Quarter-wave entry: round(32767 * sin(pi/2 * (idx + 0.5) / 2^abits)), computed in Q30.
	function automatic logic [SINE_MAG_W-1:0] sine_entry(input int unsigned idx,
			input int unsigned abits);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		x = (HALF_PI_Q30 * (64'(idx) * 64'd2 + 64'd1)) >> (abits + 1);
		term = x;
		sum = x;
		for (int k = 0; k < SERIES_TERMS; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 64'(SeriesDiv[k]);
			if ((k & 1) == 0) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		v = (sum * 64'd32767 + 64'd536870912) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[SINE_MAG_W-1:0];
	endfunction

endpackage

[src/waveform_tone_generator_unit.sv]
// Tone generator: one PCM frame per tick beat, one beat per clock while the output is
// not stalled. A tick-high beat passes the stage-1, product and output registers before
// its frame shows; a tick-low beat gives no frame. The rate comes from the phase add and
// one sine-table RAM read per beat. After reset the sine table is loaded into RAM, one
// entry per cycle, 2^SINE_TABLE_ADDR_BITS entries (256 by default), with in_ready low.
// Depends on wtg_pkg, wtg_ram, wtg_phase, wtg_scale and the assertion macros.
`include "waveform_tone_generator_unit_macros.svh"

module waveform_tone_generator_unit #(
	parameter int unsigned PHASE_BITS = 32,
	parameter int unsigned SINE_TABLE_ADDR_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [wtg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [wtg_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 tick,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [wtg_pkg::SAMPLE_W-1:0]  left_sample,
	output logic signed [wtg_pkg::SAMPLE_W-1:0]  right_sample,
	output logic                                 right_valid
);

	import wtg_pkg::*;

	localparam int unsigned TBL_SIZE = 1 << SINE_TABLE_ADDR_BITS;

	wave_t                           wave_sel_q;
	logic [STEP_W-1:0]               phase_step_q;
	logic [VOLUME_W-1:0]             volume_q;
	logic                            stereo_q;
	logic [SINE_TABLE_ADDR_BITS:0]   fill_cnt_q;
	logic                            filling;
	logic [SINE_MAG_W-1:0]           sine_rom [TBL_SIZE];
	logic                            rd_en;
	logic [SINE_TABLE_ADDR_BITS-1:0] rd_addr;
	logic [SINE_MAG_W-1:0]           rdata;
	logic                            take_s1;
	logic                            valid_s1;
	wave_beat_t                      wave_s1;

	for (genvar g = 0; g < TBL_SIZE; g++) begin : g_rom
		assign sine_rom[g] = sine_entry(g, SINE_TABLE_ADDR_BITS);
	end

	assign filling = !fill_cnt_q[SINE_TABLE_ADDR_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_sel_q <= WAVE_SINE;
			phase_step_q <= 32'd79233041;
			volume_q <= 16'd19661;
			stereo_q <= 1'b1;
			fill_cnt_q <= '0;
		end else begin
			if (filling) begin
				fill_cnt_q <= fill_cnt_q + 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_WAVE:   wave_sel_q <= wave_t'(cfg_data[1:0]);
					CFG_STEP:   phase_step_q <= cfg_data[STEP_W-1:0];
					CFG_VOLUME: volume_q <= cfg_data[VOLUME_W-1:0];
					CFG_STEREO: stereo_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	wtg_ram #(
		.WIDTH(SINE_MAG_W),
		.DEPTH(TBL_SIZE)
	) u_sine_ram (
		.clk   (clk),
		.we    (filling),
		.waddr (fill_cnt_q[SINE_TABLE_ADDR_BITS-1:0]),
		.wdata (sine_rom[fill_cnt_q[SINE_TABLE_ADDR_BITS-1:0]]),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	wtg_phase #(
		.PHASE_BITS(PHASE_BITS),
		.ADDR_BITS(SINE_TABLE_ADDR_BITS)
	) u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.tick       (tick),
		.in_ready   (in_ready),
		.filling    (filling),
		.wave_sel   (wave_sel_q),
		.phase_step (phase_step_q),
		.take_s1    (take_s1),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.valid_s1   (valid_s1),
		.wave_s1    (wave_s1)
	);

	wtg_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.wave_s1      (wave_s1),
		.rdata        (rdata),
		.volume       (volume_q),
		.stereo       (stereo_q),
		.take_s1      (take_s1),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.right_valid  (right_valid)
	);

	`WTG_ASSERT_IMP(a_fill_block, filling, !in_ready, "input taken while sine table loads")
	`WTG_ASSERT_IMP(a_stereo_eq, out_valid && right_valid, right_sample == left_sample, "right differs from left in stereo")
	`WTG_ASSERT_IMP(a_mono_zero, out_valid && !right_valid, right_sample == '0, "right not zero in mono")

endmodule

[src/wtg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wtg_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/wtg_phase.sv]
// Input stage: phase accumulator, noise LFSR, table address and first pipeline register.
// Depends on wtg_pkg and the assertion macros.
`include "waveform_tone_generator_unit_macros.svh"

module wtg_phase #(
	parameter int unsigned PHASE_BITS = 32,
	parameter int unsigned ADDR_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        tick,
	output logic                        in_ready,
	input  logic                        filling,
	input  wtg_pkg::wave_t              wave_sel,
	input  logic [wtg_pkg::STEP_W-1:0]  phase_step,
	input  logic                        take_s1,
	output logic                        rd_en,
	output logic [ADDR_BITS-1:0]        rd_addr,
	output logic                        valid_s1,
	output wtg_pkg::wave_beat_t         wave_s1
);

	import wtg_pkg::*;

	logic [PHASE_BITS-1:0] phase_acc_q;
	logic [PHASE_BITS-1:0] step_ext;
	logic [LFSR_W-1:0]     lfsr_q;
	logic [LFSR_W-1:0]     lfsr_next;
	logic                  valid_s1_q;
	wave_beat_t            wave_s1_q;
	wave_beat_t            wave_d;
	logic                  ready_s1;
	logic                  accept;
	logic [1:0]            quad;
	logic [ADDR_BITS-1:0]  idx;
	logic [15:0]           frac;
	logic [SINE_MAG_W-1:0] noise_mag;

	assign step_ext = PHASE_BITS'(phase_step);
	assign ready_s1 = !valid_s1_q || take_s1;
	assign in_ready = ready_s1 && !filling;
	assign accept = in_valid && in_ready && tick;

	assign quad = phase_acc_q[PHASE_BITS-1 -: 2];
	assign idx = phase_acc_q[PHASE_BITS-3 -: ADDR_BITS];
	assign frac = phase_acc_q[PHASE_BITS-1 -: 16];

	assign rd_en = accept;
	assign rd_addr = quad[0] ? ~idx : idx;

	always_comb begin
		lfsr_next = lfsr_q >> 1;
		if (lfsr_q[0]) begin
			lfsr_next = lfsr_next ^ LFSR_TAPS;
		end
		if (!lfsr_next[0] && (lfsr_next != '0)) begin
			noise_mag = lfsr_next[LFSR_W-1:1] - SINE_MAG_W'(1);
		end else begin
			noise_mag = lfsr_next[LFSR_W-1:1];
		end
	end

	always_comb begin
		wave_d = '0;
		case (wave_sel)
			WAVE_SINE: begin
				wave_d.is_sine = 1'b1;
				wave_d.neg = quad[1];
			end
			WAVE_SAW: begin
				wave_d.neg = !frac[15];
				if (!frac[15]) begin
					wave_d.mag = ~frac[14:0];
				end else if (frac[14:0] != '0) begin
					wave_d.mag = frac[14:0] - SINE_MAG_W'(1);
				end
			end
			WAVE_SQUARE: begin
				wave_d.neg = phase_acc_q[PHASE_BITS-1];
				wave_d.mag = FULL_SCALE;
			end
			default: begin
				wave_d.mag = noise_mag;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			lfsr_q <= LFSR_SEED;
			valid_s1_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_acc_q <= phase_acc_q + step_ext;
				if (wave_sel == WAVE_NOISE) begin
					lfsr_q <= lfsr_next;
				end
			end
			if (ready_s1) begin
				valid_s1_q <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wave_s1_q <= wave_d;
		end
	end

	assign valid_s1 = valid_s1_q;
	assign wave_s1 = wave_s1_q;

	`WTG_ASSERT_NXT(a_phase_adv, accept, phase_acc_q == $past(phase_acc_q + step_ext), "phase did not advance by step")
	`WTG_ASSERT_NXT(a_lfsr_hold, !(accept && (wave_sel == WAVE_NOISE)), $stable(lfsr_q), "noise source moved without a noise beat")

endmodule

[src/wtg_scale.sv]
// Back stages: table value merge, volume multiply, divide by 65535, sign and output register.
// Depends on wtg_pkg.
module wtg_scale (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_s1,
	input  wtg_pkg::wave_beat_t                 wave_s1,
	input  logic [wtg_pkg::SINE_MAG_W-1:0]      rdata,
	input  logic [wtg_pkg::VOLUME_W-1:0]        volume,
	input  logic                                stereo,
	output logic                                take_s1,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [wtg_pkg::SAMPLE_W-1:0] left_sample,
	output logic signed [wtg_pkg::SAMPLE_W-1:0] right_sample,
	output logic                                right_valid
);

	import wtg_pkg::*;

	localparam int unsigned PROD_W = SINE_MAG_W + VOLUME_W;

	logic                  en_out;
	logic                  valid_s2;
	logic                  neg_s2;
	logic [PROD_W-1:0]     prod_s2;
	logic [SINE_MAG_W-1:0] mag;
	logic [PROD_W-1:0]     prod;
	logic [SINE_MAG_W-1:0] q_lo;
	logic [16:0]           rem;
	logic [SINE_MAG_W-1:0] quot;
	logic [SAMPLE_W-1:0]   sample;
	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   left_q;
	logic [SAMPLE_W-1:0]   right_q;
	logic                  right_valid_q;

	assign en_out = !out_valid_q || out_ready;
	assign take_s1 = !valid_s2 || en_out;

	assign mag = wave_s1.is_sine ? rdata : wave_s1.mag;
	assign prod = PROD_W'(mag) * PROD_W'(volume);

	assign q_lo = prod_s2[PROD_W-1:16];
	assign rem = 17'(prod_s2[15:0]) + 17'(q_lo);
	assign quot = (rem >= 17'd65535) ? q_lo + SINE_MAG_W'(1) : q_lo;
	assign sample = neg_s2 ? -SAMPLE_W'(quot) : SAMPLE_W'(quot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && valid_s1) begin
			prod_s2 <= prod;
			neg_s2 <= wave_s1.neg;
		end
		if (en_out && valid_s2) begin
			left_q <= sample;
			right_q <= stereo ? sample : '0;
			right_valid_q <= stereo;
		end
	end

	assign out_valid = out_valid_q;
	assign left_sample = left_q;
	assign right_sample = right_q;
	assign right_valid = right_valid_q;

endmodule

[tb/waveform_tone_generator_unit_checker.sv]
// Frame checker for the tone generator: follows config writes and tick beats, predicts each
// PCM frame from its own phase, noise and sine-table state, and compares output beats.
// Depends on wtg_pkg.
module waveform_tone_generator_unit_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [wtg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [wtg_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic                                 tick,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic signed [wtg_pkg::SAMPLE_W-1:0]  left_sample,
	input  logic signed [wtg_pkg::SAMPLE_W-1:0]  right_sample,
	input  logic                                 right_valid,
	output int                                   mismatches,
	output int                                   frames_due
);
	timeunit 1ns;
	timeprecision 1ps;

	import wtg_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       right_on;
	} frame_t;

	frame_t pending_frames[$];
	logic [15:0] quarter_sine [256];

	wave_t              wave_sel;
	logic [STEP_W-1:0]  step_reg;
	logic [VOLUME_W-1:0] gain;
	logic               stereo;
	logic [STEP_W-1:0]  phase;
	logic [LFSR_W-1:0]  lfsr;
	int                 fail_count;

	initial begin : build_quarter_sine
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		for (int i = 0; i < 256; i++) begin
			x = (HALF_PI_Q30 * 64'(2 * i + 1)) / 64'd512;
			term = x;
			sum = x;
			for (int k = 1; k <= 6; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					sum = (sum >= term) ? sum - term : 64'd0;
				end else begin
					sum = sum + term;
				end
			end
			v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			quarter_sine[i] = v[15:0];
		end
	end

	function automatic frame_t next_frame();
		int          w;
		longint      pos;
		longint      d;
		longint      nz;
		longint      mag;
		longint      s;
		logic [1:0]  quad;
		logic [7:0]  idx;
		logic        lsb;
		frame_t      f;
		case (wave_sel)
			WAVE_SINE: begin
				quad = phase[31:30];
				idx = phase[29:22];
				if (quad[0]) begin
					idx = 8'd255 - idx;
				end
				w = int'(quarter_sine[idx]);
				if (quad[1]) begin
					w = -w;
				end
			end
			WAVE_SAW: begin
				pos = longint'(phase[31:16]);
				d = 2 * pos - 65536;
				w = int'((d * 32767) / 65536);
			end
			WAVE_SQUARE: begin
				w = phase[31] ? -32767 : 32767;
			end
			default: begin
				lsb = lfsr[0];
				lfsr = lfsr >> 1;
				if (lsb) begin
					lfsr = lfsr ^ LFSR_TAPS;
				end
				nz = longint'(lfsr);
				w = int'((nz * 32767) / 65535);
			end
		endcase
		mag = longint'((w < 0) ? -w : w);
		mag = (mag * longint'(gain)) / 65535;
		s = (w < 0) ? -mag : mag;
		phase = phase + step_reg;
		f.left = s[15:0];
		f.right = stereo ? s[15:0] : 16'sd0;
		f.right_on = stereo;
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_t want;
		frame_t got;
		if (!arst_n) begin
			wave_sel = WAVE_SINE;
			step_reg = 32'd79233041;
			gain = 16'd19661;
			stereo = 1'b1;
			phase = '0;
			lfsr = LFSR_SEED;
			pending_frames.delete();
			fail_count = 0;
			mismatches <= 0;
			frames_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_WAVE:   wave_sel = wave_t'(cfg_data[1:0]);
					CFG_STEP:   step_reg = cfg_data[STEP_W-1:0];
					CFG_VOLUME: gain = cfg_data[VOLUME_W-1:0];
					CFG_STEREO: stereo = cfg_data[0];
				endcase
			end
			if (in_valid && in_ready && tick) begin
				pending_frames.push_back(next_frame());
			end
			if (out_valid && out_ready) begin
				got.left = left_sample;
				got.right = right_sample;
				got.right_on = right_valid;
				if (pending_frames.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: unexpected frame left %0d right %0d rvalid %0b",
							$realtime, got.left, got.right, got.right_on);
					end
				end else begin
					want = pending_frames.pop_front();
					if (want.left !== got.left || want.right !== got.right ||
							want.right_on !== got.right_on) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: frame mismatch left %0d/%0d right %0d/%0d rvalid %0b/%0b",
								$realtime, want.left, got.left, want.right, got.right,
								want.right_on, got.right_on);
						end
					end
				end
			end
			mismatches <= fail_count;
			frames_due <= pending_frames.size();
		end
	end

endmodule

[tb/waveform_tone_generator_unit_tb.sv]
// Stimulus top for the tone generator: drives tick beats, config writes and output stalls,
// and gives the verdict from the frame checker's counts and a stall watchdog.
// Depends on wtg_pkg, waveform_tone_generator_unit and waveform_tone_generator_unit_checker.
module waveform_tone_generator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wtg_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int LATENCY = 3;
	localparam int SETTLE_CYCLES = LATENCY + 2;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int SEG_TICKS = 90;
	localparam int SendIdle [4] = '{0, 51, 0, 33};
	localparam int RecvStall [4] = '{0, 0, 51, 33};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic tick;
	logic out_valid;
	logic out_ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic right_valid;
	int mismatches;
	int frames_due;

	int send_idle_pct;
	int recv_stall_pct;
	logic holdoff_req;

	always #(CLK_PERIOD / 2) clk = ~clk;

	waveform_tone_generator_unit u_top (.*);

	waveform_tone_generator_unit_checker u_check (.*);

	wire any_beat = (in_valid && in_ready) || (out_valid && out_ready);

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (any_beat) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : sink
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic send_beat(input logic t);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			tick <= 1'($urandom_range(0, 1));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		tick <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_burst(input int n_ticks, input int zero_pct);
		int sent;
		sent = 0;
		while (sent < n_ticks) begin
			if ($urandom_range(0, 99) < zero_pct) begin
				send_beat(1'b0);
			end else begin
				send_beat(1'b1);
				sent++;
			end
		end
	endtask

	// Drop valid, wait out every frame in flight, then let the pipe settle.
	task automatic drain_block();
		in_valid <= 1'b0;
		do @(posedge clk); while (frames_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings(input wave_t w, input logic [31:0] step,
			input logic [15:0] vol, input logic st);
		drain_block();
		cfg_we <= 1'b1;
		cfg_index <= CFG_WAVE;
		cfg_data <= ($urandom() & ~32'h3) | 32'(w);
		@(posedge clk);
		cfg_index <= CFG_STEP;
		cfg_data <= step;
		@(posedge clk);
		cfg_index <= CFG_VOLUME;
		cfg_data <= ($urandom() & ~32'hFFFF) | 32'(vol);
		@(posedge clk);
		cfg_index <= CFG_STEREO;
		cfg_data <= ($urandom() & ~32'h1) | 32'(st);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [31:0] step;
		logic [15:0] vol;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_WAVE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		tick <= 1'b0;
		holdoff_req <= 1'b0;
		recv_stall_pct <= 0;
		send_idle_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, with a tick-low beat in the middle.
		send_burst(2, 0);
		send_beat(1'b0);
		send_burst(2, 0);

		load_settings(WAVE_SAW, 32'h4000_0000, 16'hFFFF, 1'b0);
		send_burst(4, 0);
		load_settings(WAVE_SQUARE, 32'h8000_0000, 16'h0000, 1'b1);
		send_burst(2, 0);
		send_beat(1'b0);
		load_settings(WAVE_NOISE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_burst(4, 0);
		load_settings(WAVE_SINE, 32'h0000_0000, 16'hFFFF, 1'b0);
		send_burst(2, 0);
		load_settings(WAVE_SINE, 32'h4040_0000, 16'hFFFF, 1'b1);
		send_burst(3, 0);

		for (int ph = 0; ph < 4; ph++) begin
			for (int seg = 0; seg < 4; seg++) begin
				case ($urandom_range(0, 5))
					0: step = $urandom_range(0, 65535) << 12;
					1: step = 32'd0;
					2: step = 32'hFFFF_FFFF;
					3: step = 32'h0040_0000 * $urandom_range(1, 64);
					default: step = $urandom();
				endcase
				case ($urandom_range(0, 4))
					0: vol = 16'h0000;
					1: vol = 16'hFFFF;
					default: vol = 16'($urandom_range(0, 65535));
				endcase
				load_settings(wave_t'((seg + ph) % 4), step, vol, 1'($urandom_range(0, 1)));
				send_idle_pct = SendIdle[ph];
				recv_stall_pct <= RecvStall[ph];
				send_burst(SEG_TICKS, 10);
			end
		end

		// Hold the output off while ticks keep coming, so the input backs up.
		load_settings(wave_t'($urandom_range(0, 3)), $urandom(),
			16'($urandom_range(0, 65535)), 1'b1);
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		holdoff_req <= 1'b1;
		send_burst(120, 0);

		drain_block();
		if (mismatches == 0 && frames_due == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
